/* design/circle_collision_resolver_unit_macros.svh */
// Assertion macros for the collision resolver unit.
// Both macros use the module's clk and rst_n.
`ifndef CIRCLE_COLLISION_RESOLVER_UNIT_MACROS_SVH
`define CIRCLE_COLLISION_RESOLVER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("collision resolver check failed");
`define CCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("collision resolver check failed");
`else
`define CCR_ASSERT_IMP(lbl, ante, cons)
`define CCR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* design/ccr_pkg.sv */
`default_nettype none
package ccr_pkg;

  localparam logic [1:0] ACT_LOAD_AGENT = 2'd0;
  localparam logic [1:0] ACT_LOAD_OBST  = 2'd1;
  localparam logic [1:0] ACT_RUN        = 2'd2;
  localparam logic [1:0] ACT_IGNORED    = 2'd3;

  localparam logic [1:0] REG_AGENT_SCALE = 2'd0;
  localparam logic [1:0] REG_OBST_SCALE  = 2'd1;
  localparam logic [1:0] REG_AGENT_COUNT = 2'd2;
  localparam logic [1:0] REG_OBST_COUNT  = 2'd3;

  localparam int SQRT_IN_W  = 62;
  localparam int SQRT_OUT_W = 31;
  localparam int DIV_NUM_W  = 60;
  localparam int DIV_DEN_W  = 30;
  localparam int DIV_Q_W    = 30;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] r;
  } ent_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_I_RD,
    ST_I_CAP,
    ST_J_SEL,
    ST_J_CAP,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQT,
    ST_TEST,
    ST_SQRT,
    ST_MULX,
    ST_DSTX,
    ST_DIVX,
    ST_MULY,
    ST_DSTY,
    ST_DIVY,
    ST_JWB,
    ST_ADV,
    ST_IWB,
    ST_O_RD,
    ST_O_CAP,
    ST_O_WAIT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    if (v > 34'sh0_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/ccr_ram.sv */
`default_nettype none
module ccr_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/ccr_sqrt.sv */
`default_nettype none
module ccr_sqrt
  import ccr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [SQRT_IN_W-1:0]  radicand,
  output logic                       done,
  output logic      [SQRT_OUT_W-1:0] root
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [SQRT_IN_W-1:0]  sh_r, sh_nxt;
  logic [33:0]           rem_r, rem_nxt;
  logic [SQRT_OUT_W-1:0] root_r, root_nxt;
  logic [35:0]           rem2;
  logic [35:0]           trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem2     = {rem_r, sh_r[SQRT_IN_W-1 -: 2]};
    trial    = {3'b000, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(SQRT_OUT_W);
      sh_nxt   = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem2 >= trial) begin
        rem_nxt  = 34'(rem2 - trial);
        root_nxt = {root_r[SQRT_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2[33:0];
        root_nxt = {root_r[SQRT_OUT_W-2:0], 1'b0};
      end
      sh_nxt  = {sh_r[SQRT_IN_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

/* design/ccr_div.sv */
`default_nettype none
module ccr_div
  import ccr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] dividend,
  input  wire logic [DIV_DEN_W-1:0] divisor,
  output logic                      done,
  output logic      [DIV_Q_W-1:0]   quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_Q_W-1:0]   low_r, low_nxt;
  logic [DIV_Q_W-1:0]   q_r, q_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   r2;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    r2       = {rem_r, low_r[DIV_Q_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(DIV_Q_W);
      rem_nxt  = dividend[DIV_NUM_W-1 -: DIV_DEN_W];
      low_nxt  = dividend[DIV_Q_W-1:0];
      q_nxt    = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (r2 >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(r2 - {1'b0, den_r});
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = r2[DIV_DEN_W-1:0];
        q_nxt   = {q_r[DIV_Q_W-2:0], 1'b0};
      end
      low_nxt = {low_r[DIV_Q_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

/* design/circle_collision_resolver_unit.sv */
// Loads of an agent or an obstacle are taken only while idle and give no result.
// A run reads each agent and tests it against every later agent and every obstacle;
// an overlap adds a square root and two divides, and a write-back if the other is an agent.
// Each report is held until the output is not stalled; the input stalls for the whole run.
// Synchronous active-low reset clears control, scales to 4096, counts and hit flags to
// zero; position memories are not cleared.
`default_nettype none
`include "circle_collision_resolver_unit_macros.svh"
module circle_collision_resolver_unit
  import ccr_pkg::*;
#(
  parameter int MAX_AGENTS    = 32,
  parameter int MAX_OBSTACLES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [4:0]  in_slot,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [23:0] in_radius,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_agent_slot,
  output logic [31:0]      out_new_x,
  output logic [31:0]      out_new_y,
  output logic             out_collided,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int OAW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW  = $clog2(MAX_AGENTS + 1);
  localparam int OCW = $clog2(MAX_OBSTACLES + 1);
  localparam int EW  = $bits(ent_t);

  state_t state_r, state_nxt;

  logic [15:0] agent_scale_r, obst_scale_r;
  logic [5:0]  agent_count_r, obst_count_r;

  logic [CW-1:0]  na_r, na_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [OCW-1:0] no_r, no_nxt, k_r, k_nxt;
  logic [MAX_AGENTS-1:0] hit_r, hit_nxt;
  logic pair_obs_r, pair_obs_nxt;
  logic cur_hit_r, cur_hit_nxt;
  logic out_valid_r, out_valid_nxt;

  ent_t cur_r, cur_nxt, oth_r, oth_nxt;
  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [32:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic far_r, far_nxt;
  logic [28:0] t_r, t_nxt, d_r, d_nxt, gap_r, gap_nxt;
  logic [61:0] ax2_r, ax2_nxt, d2_r, d2_nxt, mul_p_r;
  logic [30:0] mul_a, mul_b;

  logic [4:0]  oslot_r, oslot_nxt;
  logic [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic        ocoll_r, ocoll_nxt, olast_r, olast_nxt;

  logic          agent_we, obst_we;
  logic [AW-1:0] agent_waddr, agent_raddr;
  logic [OAW-1:0] obst_waddr, obst_raddr;
  ent_t agent_wdata, obst_wdata, agent_rdata, obst_rdata;

  logic sq_start, sq_done, div_start, div_done;
  logic [SQRT_OUT_W-1:0] sq_root;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_Q_W-1:0]    div_q;
  logic [DIV_DEN_W-1:0]  div_den;

  logic in_acc;
  logic signed [32:0] ddx, ddy;
  logic [24:0] rsum;
  logic [58:0] num;
  logic [31:0] corr;
  logic        corr_neg;
  logic [28:0] root_d;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_agent_slot = oslot_r;
  assign out_new_x      = ox_r;
  assign out_new_y      = oy_r;
  assign out_collided   = ocoll_r;
  assign out_last       = olast_r;

  ccr_ram #(.WIDTH(EW), .DEPTH(MAX_AGENTS), .AW(AW)) u_agent_ram (
    .clk  (clk),
    .we   (agent_we),
    .waddr(agent_waddr),
    .wdata(agent_wdata),
    .raddr(agent_raddr),
    .rdata(agent_rdata)
  );

  ccr_ram #(.WIDTH(EW), .DEPTH(MAX_OBSTACLES), .AW(OAW)) u_obst_ram (
    .clk  (clk),
    .we   (obst_we),
    .waddr(obst_waddr),
    .wdata(obst_wdata),
    .raddr(obst_raddr),
    .rdata(obst_rdata)
  );

  ccr_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(d2_r),
    .done    (sq_done),
    .root    (sq_root)
  );

  ccr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (div_den),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_action == ACT_RUN && agent_count_r != 6'd0) begin
          state_nxt = ST_I_RD;
        end
      end
      ST_I_RD:  state_nxt = ST_I_CAP;
      ST_I_CAP: state_nxt = ST_J_SEL;
      ST_J_SEL: begin
        if (j_r < na_r || k_r < no_r) begin
          state_nxt = ST_J_CAP;
        end else begin
          state_nxt = ST_IWB;
        end
      end
      ST_J_CAP: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SQT;
      ST_SQT:   state_nxt = ST_TEST;
      ST_TEST: begin
        if (!far_r && d2_r != '0 && d2_r <= mul_p_r) begin
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: state_nxt = ST_DSTX;
      ST_DSTX: state_nxt = ST_DIVX;
      ST_DIVX: begin
        if (div_done) begin
          state_nxt = ST_MULY;
        end
      end
      ST_MULY: state_nxt = ST_DSTY;
      ST_DSTY: state_nxt = ST_DIVY;
      ST_DIVY: begin
        if (div_done) begin
          state_nxt = pair_obs_r ? ST_ADV : ST_JWB;
        end
      end
      ST_JWB: state_nxt = ST_ADV;
      ST_ADV: state_nxt = ST_J_SEL;
      ST_IWB: begin
        if (CW'(i_r + 1'b1) < na_r) begin
          state_nxt = ST_I_RD;
        end else begin
          state_nxt = ST_O_RD;
        end
      end
      ST_O_RD:  state_nxt = ST_O_CAP;
      ST_O_CAP: state_nxt = ST_O_WAIT;
      ST_O_WAIT: begin
        if (!out_stall) begin
          state_nxt = olast_r ? ST_IDLE : ST_O_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    na_nxt        = na_r;
    no_nxt        = no_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    pair_obs_nxt  = pair_obs_r;
    cur_hit_nxt   = cur_hit_r;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    oth_nxt       = oth_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    far_nxt       = far_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    gap_nxt       = gap_r;
    ax2_nxt       = ax2_r;
    d2_nxt        = d2_r;
    oslot_nxt     = oslot_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    ocoll_nxt     = ocoll_r;
    olast_nxt     = olast_r;
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;
    div_start     = 1'b0;
    agent_we      = 1'b0;
    agent_waddr   = AW'(in_slot);
    agent_wdata   = '{x: in_pos_x, y: in_pos_y, r: in_radius};
    agent_raddr   = i_r[AW-1:0];
    obst_we       = 1'b0;
    obst_waddr    = OAW'(in_slot);
    obst_wdata    = '{x: in_pos_x, y: in_pos_y, r: in_radius};
    obst_raddr    = k_r[OAW-1:0];
    ddx  = $signed({cur_r.x[31], cur_r.x}) - $signed({oth_r.x[31], oth_r.x});
    ddy  = $signed({cur_r.y[31], cur_r.y}) - $signed({oth_r.y[31], oth_r.y});
    rsum = {1'b0, cur_r.r} + {1'b0, oth_r.r};
    num  = mul_p_r[58:0];
    corr_neg = 1'b0;
    corr     = {2'b00, div_q};
    root_d   = (sq_root == '0) ? 29'd1 : sq_root[28:0];
    div_num  = pair_obs_r ? ({num, 1'b0} + DIV_NUM_W'(d_r)) :
                            (DIV_NUM_W'(num) + DIV_NUM_W'(d_r));
    div_den  = {d_r, 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_LOAD_AGENT && int'(in_slot) < MAX_AGENTS) begin
            agent_we = 1'b1;
          end
          if (in_action == ACT_LOAD_OBST && int'(in_slot) < MAX_OBSTACLES) begin
            obst_we = 1'b1;
          end
          if (in_action == ACT_RUN) begin
            na_nxt = (int'(agent_count_r) > MAX_AGENTS) ? CW'(MAX_AGENTS) :
                                                          CW'(agent_count_r);
            no_nxt = (int'(obst_count_r) > MAX_OBSTACLES) ? OCW'(MAX_OBSTACLES) :
                                                            OCW'(obst_count_r);
            i_nxt  = '0;
          end
        end
      end
      ST_I_RD: begin
        agent_raddr = i_r[AW-1:0];
      end
      ST_I_CAP: begin
        cur_nxt     = agent_rdata;
        cur_hit_nxt = 1'b0;
        j_nxt       = CW'(i_r + 1'b1);
        k_nxt       = '0;
      end
      ST_J_SEL: begin
        agent_raddr  = j_r[AW-1:0];
        obst_raddr   = k_r[OAW-1:0];
        pair_obs_nxt = !(j_r < na_r);
      end
      ST_J_CAP: begin
        oth_nxt = pair_obs_r ? obst_rdata : agent_rdata;
      end
      ST_DIFF: begin
        dx_nxt = ddx;
        dy_nxt = ddy;
        ax_nxt = ddx[32] ? 33'(-ddx) : 33'(ddx);
        ay_nxt = ddy[32] ? 33'(-ddy) : 33'(ddy);
        mul_a  = 31'(pair_obs_r ? obst_scale_r : agent_scale_r);
        mul_b  = 31'(rsum);
      end
      ST_SQX: begin
        t_nxt   = mul_p_r[40:12];
        far_nxt = (ax_r > 33'h0_4000_0000) || (ay_r > 33'h0_4000_0000);
        mul_a   = ax_r[30:0];
        mul_b   = ax_r[30:0];
      end
      ST_SQY: begin
        ax2_nxt = mul_p_r;
        mul_a   = ay_r[30:0];
        mul_b   = ay_r[30:0];
      end
      ST_SQT: begin
        d2_nxt = ax2_r + mul_p_r;
        mul_a  = 31'(t_r);
        mul_b  = 31'(t_r);
      end
      ST_TEST: begin
        if (!far_r && d2_r != '0 && d2_r <= mul_p_r) begin
          sq_start = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          d_nxt   = root_d;
          gap_nxt = t_r - root_d;
        end
      end
      ST_MULX: begin
        mul_a = 31'(gap_r);
        mul_b = ax_r[30:0];
      end
      ST_DSTX: begin
        div_start = 1'b1;
      end
      ST_DIVX: begin
        if (div_done) begin
          corr_neg = dx_r[32];
          corr     = corr_neg ? 32'(-{2'b00, div_q}) : {2'b00, div_q};
          cur_nxt.x = sat32($signed({{2{cur_r.x[31]}}, cur_r.x}) +
                            $signed({{2{corr[31]}}, corr}));
          oth_nxt.x = sat32($signed({{2{oth_r.x[31]}}, oth_r.x}) -
                            $signed({{2{corr[31]}}, corr}));
        end
      end
      ST_MULY: begin
        mul_a = 31'(gap_r);
        mul_b = ay_r[30:0];
      end
      ST_DSTY: begin
        div_start = 1'b1;
      end
      ST_DIVY: begin
        if (div_done) begin
          corr_neg = dy_r[32];
          corr     = corr_neg ? 32'(-{2'b00, div_q}) : {2'b00, div_q};
          cur_nxt.y = sat32($signed({{2{cur_r.y[31]}}, cur_r.y}) +
                            $signed({{2{corr[31]}}, corr}));
          oth_nxt.y = sat32($signed({{2{oth_r.y[31]}}, oth_r.y}) -
                            $signed({{2{corr[31]}}, corr}));
          cur_hit_nxt = 1'b1;
        end
      end
      ST_JWB: begin
        agent_we    = 1'b1;
        agent_waddr = j_r[AW-1:0];
        agent_wdata = oth_r;
      end
      ST_ADV: begin
        if (pair_obs_r) begin
          k_nxt = OCW'(k_r + 1'b1);
        end else begin
          j_nxt = CW'(j_r + 1'b1);
        end
      end
      ST_IWB: begin
        agent_we               = 1'b1;
        agent_waddr            = i_r[AW-1:0];
        agent_wdata            = cur_r;
        hit_nxt[i_r[AW-1:0]]   = cur_hit_r;
        i_nxt = (CW'(i_r + 1'b1) < na_r) ? CW'(i_r + 1'b1) : '0;
      end
      ST_O_RD: begin
        agent_raddr = i_r[AW-1:0];
      end
      ST_O_CAP: begin
        oslot_nxt     = 5'(i_r);
        ox_nxt        = agent_rdata.x;
        oy_nxt        = agent_rdata.y;
        ocoll_nxt     = hit_r[i_r[AW-1:0]];
        olast_nxt     = (i_r == CW'(na_r - 1'b1));
        out_valid_nxt = 1'b1;
      end
      ST_O_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          i_nxt         = CW'(i_r + 1'b1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      agent_scale_r <= 16'd4096;
      obst_scale_r  <= 16'd4096;
      agent_count_r <= '0;
      obst_count_r  <= '0;
      hit_r         <= '0;
      out_valid_r   <= 1'b0;
      na_r          <= '0;
      no_r          <= '0;
      i_r           <= '0;
      j_r           <= '0;
      k_r           <= '0;
      pair_obs_r    <= 1'b0;
      cur_hit_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      na_r        <= na_nxt;
      no_r        <= no_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      pair_obs_r  <= pair_obs_nxt;
      cur_hit_r   <= cur_hit_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AGENT_SCALE: agent_scale_r <= cfg_data;
          REG_OBST_SCALE:  obst_scale_r  <= cfg_data;
          REG_AGENT_COUNT: agent_count_r <= cfg_data[5:0];
          REG_OBST_COUNT:  obst_count_r  <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    oth_r   <= oth_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    far_r   <= far_nxt;
    t_r     <= t_nxt;
    d_r     <= d_nxt;
    gap_r   <= gap_nxt;
    ax2_r   <= ax2_nxt;
    d2_r    <= d2_nxt;
    mul_p_r <= {31'b0, mul_a} * {31'b0, mul_b};
    oslot_r <= oslot_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    ocoll_r <= ocoll_nxt;
    olast_r <= olast_nxt;
  end

  `CCR_ASSERT_IMP(a_ready_not_reporting, !in_stall, !out_valid)
  `CCR_ASSERT_IMP(a_last_is_final_agent, out_valid && out_last, i_r == CW'(na_r - 1'b1))
  `CCR_ASSERT_NXT(a_idle_after_last, out_valid && !out_stall && out_last, !in_stall)
  `CCR_ASSERT_IMP(a_writeback_in_range, state_r == ST_IWB, i_r < na_r)

endmodule
`default_nettype wire

/* tb/circle_collision_resolver_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module circle_collision_resolver_checker
  import ccr_pkg::*;
#(
  parameter int MAX_AGENTS    = 32,
  parameter int MAX_OBSTACLES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [4:0]  in_slot,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [23:0] in_radius,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [4:0]  out_agent_slot,
  input  wire logic [31:0] out_new_x,
  input  wire logic [31:0] out_new_y,
  input  wire logic        out_collided,
  input  wire logic        out_last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               report_count
);

  typedef struct {
    logic [4:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic        hit;
    logic        last;
  } agent_report_t;

  agent_report_t reports_due[$];

  longint      agent_px[MAX_AGENTS];
  longint      agent_py[MAX_AGENTS];
  logic [23:0] agent_rad[MAX_AGENTS];
  logic        agent_hit_flag[MAX_AGENTS];
  longint      obst_px[MAX_OBSTACLES];
  longint      obst_py[MAX_OBSTACLES];
  logic [23:0] obst_rad[MAX_OBSTACLES];
  logic [15:0] agent_scale;
  logic [15:0] obst_scale;
  logic [5:0]  agent_cnt;
  logic [5:0]  obst_cnt;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint saturate(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit circles_overlap(input longint dx, input longint dy,
                                         input logic [15:0] scale, input logic [24:0] rsum,
                                         output logic [63:0] gap,
                                         output logic [63:0] root_dist);
    logic [63:0] t;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] d2;
    gap = 0;
    root_dist = 1;
    t = (64'(scale) * 64'(rsum)) >> 12;
    mx = magnitude(dx);
    my = magnitude(dy);
    if (mx > (64'd1 << 30) || my > (64'd1 << 30)) return 0;
    d2 = mx * mx + my * my;
    if (d2 == 0 || d2 > t * t) return 0;
    root_dist = int_sqrt(d2);
    if (root_dist == 0) root_dist = 1;
    gap = t - root_dist;
    return 1;
  endfunction

  function automatic longint push_share(input longint comp, input logic [63:0] gap,
                                        input logic [63:0] d, input bit half);
    logic [63:0] num;
    logic [63:0] q;
    num = gap * magnitude(comp);
    q = half ? (num + d) / (2 * d) : (2 * num + d) / (2 * d);
    return comp < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic resolve_pass();
    int          na;
    int          no;
    bit          hit;
    logic [63:0] gap;
    logic [63:0] d;
    longint      dx;
    longint      dy;
    longint      cx;
    longint      cy;
    agent_report_t rep;
    na = agent_cnt > MAX_AGENTS ? MAX_AGENTS : int'(agent_cnt);
    no = obst_cnt > MAX_OBSTACLES ? MAX_OBSTACLES : int'(obst_cnt);
    for (int i = 0; i < na; i++) begin
      hit = 0;
      agent_hit_flag[i] = 0;
      for (int j = i + 1; j < na; j++) begin
        dx = agent_px[i] - agent_px[j];
        dy = agent_py[i] - agent_py[j];
        if (circles_overlap(dx, dy, agent_scale, 25'(agent_rad[i]) + 25'(agent_rad[j]),
                            gap, d)) begin
          cx = push_share(dx, gap, d, 1);
          cy = push_share(dy, gap, d, 1);
          hit = 1;
          agent_px[i] = saturate(agent_px[i] + cx);
          agent_py[i] = saturate(agent_py[i] + cy);
          agent_px[j] = saturate(agent_px[j] - cx);
          agent_py[j] = saturate(agent_py[j] - cy);
        end
      end
      for (int j = 0; j < no; j++) begin
        dx = agent_px[i] - obst_px[j];
        dy = agent_py[i] - obst_py[j];
        if (circles_overlap(dx, dy, obst_scale, 25'(agent_rad[i]) + 25'(obst_rad[j]),
                            gap, d)) begin
          hit = 1;
          agent_px[i] = saturate(agent_px[i] + push_share(dx, gap, d, 0));
          agent_py[i] = saturate(agent_py[i] + push_share(dy, gap, d, 0));
        end
      end
      agent_hit_flag[i] = hit;
    end
    for (int i = 0; i < na; i++) begin
      rep.slot = 5'(i);
      rep.x = agent_px[i][31:0];
      rep.y = agent_py[i][31:0];
      rep.hit = agent_hit_flag[i];
      rep.last = (i == na - 1);
      reports_due = {reports_due, rep};
    end
  endtask

  always @(posedge clk) begin
    agent_report_t want;
    if (!rst_n) begin
      agent_scale <= 16'd4096;
      obst_scale <= 16'd4096;
      agent_cnt <= '0;
      obst_cnt <= '0;
      for (int k = 0; k < MAX_AGENTS; k++) agent_hit_flag[k] = 0;
      reports_due.delete();
      fail_count <= 0;
      report_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_LOAD_AGENT: begin
            agent_px[in_slot] = longint'($signed(in_pos_x));
            agent_py[in_slot] = longint'($signed(in_pos_y));
            agent_rad[in_slot] = in_radius;
          end
          ACT_LOAD_OBST: begin
            obst_px[in_slot] = longint'($signed(in_pos_x));
            obst_py[in_slot] = longint'($signed(in_pos_y));
            obst_rad[in_slot] = in_radius;
          end
          ACT_RUN: resolve_pass();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        report_count <= report_count + 1;
        if (reports_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("Unexpected agent report: slot %0d x %h y %h collided %b last %b",
                     out_agent_slot, out_new_x, out_new_y, out_collided, out_last);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = reports_due.pop_front();
          if (want.slot !== out_agent_slot || want.x !== out_new_x || want.y !== out_new_y ||
              want.hit !== out_collided || want.last !== out_last) begin
            if (fail_count < 10) begin
              $display("Agent report mismatch: expected slot %0d x %h y %h collided %b last %b",
                       want.slot, want.x, want.y, want.hit, want.last);
              $display("                       actual   slot %0d x %h y %h collided %b last %b",
                       out_agent_slot, out_new_x, out_new_y, out_collided, out_last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AGENT_SCALE: agent_scale <= cfg_data;
          REG_OBST_SCALE:  obst_scale <= cfg_data;
          REG_AGENT_COUNT: agent_cnt <= cfg_data[5:0];
          REG_OBST_COUNT:  obst_cnt <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
    pending <= reports_due.size();
  end

endmodule
`default_nettype wire

/* tb/circle_collision_resolver_unit_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module circle_collision_resolver_unit_test;
  import ccr_pkg::*;

  localparam int IDLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [4:0]  in_slot;
  logic [31:0] in_pos_x;
  logic [31:0] in_pos_y;
  logic [23:0] in_radius;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_agent_slot;
  logic [31:0] out_new_x;
  logic [31:0] out_new_y;
  logic        out_collided;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int report_count;
  int idle_cycles;
  int item_count;
  int run_count;
  int setting_count;
  bit burst_mode;
  logic [31:0] agents_loaded;
  logic [31:0] obsts_loaded;
  logic [31:0] center_x;
  logic [31:0] center_y;

  circle_collision_resolver_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_slot(in_slot),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_radius(in_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_agent_slot(out_agent_slot),
    .out_new_x(out_new_x), .out_new_y(out_new_y), .out_collided(out_collided),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  circle_collision_resolver_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action), .in_slot(in_slot),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_radius(in_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_agent_slot(out_agent_slot),
    .out_new_x(out_new_x), .out_new_y(out_new_y), .out_collided(out_collided),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .report_count(report_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out with %0d agent reports outstanding.", pending);
      $display("circle_collision_resolver_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = (burst_mode || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int loaded_prefix(input logic [31:0] mask);
    int n;
    n = 0;
    while (n < 32 && mask[n]) n++;
    return n;
  endfunction

  task automatic send_item(input logic [1:0] action, input logic [4:0] slot,
                           input logic [31:0] x, input logic [31:0] y, input logic [23:0] r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_slot <= slot;
    in_pos_x <= x;
    in_pos_y <= y;
    in_radius <= r;
    do @(posedge clk); while (in_stall);
    if (action == ACT_LOAD_AGENT) agents_loaded[slot] = 1'b1;
    if (action == ACT_LOAD_OBST) obsts_loaded[slot] = 1'b1;
    if (action == ACT_RUN) run_count++;
    if (action != ACT_IGNORED) item_count++;
  endtask

  task automatic run_pass();
    send_item(ACT_RUN, 5'($urandom), $urandom, $urandom, 24'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_count(input int prefix);
    if (prefix == 32 && $urandom_range(0, 5) == 0) return 6'($urandom_range(32, 63));
    if (prefix > 8 && $urandom_range(0, 5) != 0) return 6'($urandom_range(0, 8));
    return 6'($urandom_range(0, prefix));
  endfunction

  task automatic load_random(input bit obstacle);
    int          prefix;
    logic [4:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [23:0] r;
    prefix = loaded_prefix(obstacle ? obsts_loaded : agents_loaded);
    slot = 5'($urandom_range(0, prefix > 31 ? 31 : prefix));
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom;
      y = $urandom;
      r = 24'($urandom);
    end else begin
      x = center_x + $urandom_range(0, 1 << 19) - (1 << 18);
      y = center_y + $urandom_range(0, 1 << 19) - (1 << 18);
      r = 24'($urandom_range(1 << 14, 1 << 18));
    end
    send_item(obstacle ? ACT_LOAD_OBST : ACT_LOAD_AGENT, slot, x, y, r);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_LOAD_AGENT;
    in_slot <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_radius <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AGENT_SCALE;
    cfg_data <= '0;
    idle_cycles = 0;
    item_count = 0;
    run_count = 0;
    setting_count = 0;
    burst_mode = 0;
    agents_loaded = '0;
    obsts_loaded = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // With reset counts a run reports nothing.
    run_pass();
    drain();
    send_item(ACT_LOAD_AGENT, 5'd0, 32'h0000_0000, 32'h0000_0000, 24'h01_0000);
    send_item(ACT_LOAD_AGENT, 5'd1, 32'h0000_8000, 32'hFFFF_C000, 24'h01_0000);
    send_item(ACT_LOAD_AGENT, 5'd2, 32'h0064_0000, 32'h0064_0000, 24'h00_8000);
    send_item(ACT_LOAD_AGENT, 5'd3, 32'h0064_0000, 32'h0064_0000, 24'h00_8000);
    send_item(ACT_LOAD_AGENT, 5'd4, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 24'hFF_FFFF);
    send_item(ACT_LOAD_AGENT, 5'd5, 32'h8000_0000, 32'h8000_0000, 24'h00_0000);
    send_item(ACT_LOAD_OBST, 5'd0, 32'h0064_0000, 32'h0064_C000, 24'h00_8000);
    send_item(ACT_LOAD_OBST, 5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_item(ACT_IGNORED, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    drain();
    write_reg(REG_AGENT_COUNT, 16'd6);
    write_reg(REG_OBST_COUNT, 16'd2);
    setting_count++;
    run_pass();
    run_pass();
    drain();
    write_reg(REG_AGENT_SCALE, 16'hFFFF);
    write_reg(REG_OBST_SCALE, 16'd0);
    setting_count++;
    run_pass();
    drain();

    while (item_count < 220) begin
      write_reg(REG_AGENT_SCALE, pick_scale());
      write_reg(REG_OBST_SCALE, pick_scale());
      write_reg(REG_AGENT_COUNT, 16'(pick_count(loaded_prefix(agents_loaded))));
      write_reg(REG_OBST_COUNT, 16'(pick_count(loaded_prefix(obsts_loaded))));
      setting_count++;
      burst_mode = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0: begin
          center_x = 32'h7FFF_0000;
          center_y = 32'h8001_0000;
        end
        1: begin
          center_x = $urandom;
          center_y = $urandom;
        end
        default: begin
          center_x = 32'h0;
          center_y = 32'h0;
        end
      endcase
      repeat ($urandom_range(1, 8)) load_random($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) begin
        send_item(ACT_IGNORED, 5'($urandom), $urandom, $urandom, 24'($urandom));
      end
      run_pass();
      if ($urandom_range(0, 2) == 0) run_pass();
      drain();
    end

    burst_mode = 0;
    repeat (140) @(posedge clk);
    $display("Sent %0d loads and runs (%0d runs) over %0d register settings;", item_count,
             run_count, setting_count);
    $display("checked %0d agent reports.", report_count);
    if (fail_count == 0 && pending == 0) begin
      $display("circle_collision_resolver_unit_test: PASS");
    end else begin
      $display("circle_collision_resolver_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
